### sv/rap_pkg.sv
`timescale 1ns / 1ps

package rap_pkg;

   localparam int NUM_PAGES      = 32768;
   localparam int REF_BITS       = 8;
   localparam int PAGE_BITS      = $clog2(NUM_PAGES);
   localparam int DEPTH_BITS     = $clog2(NUM_PAGES + 1);
   localparam int MODE_BITS      = 3;
   localparam int STATUS_BITS    = 3;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_IDX_BITS   = CSR_ADDR_BITS - 2;
   localparam int REQ_TDATA_BITS = ((PAGE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((PAGE_BITS + REF_BITS + 7) / 8) * 8;

   localparam logic [REF_BITS-1:0]     REF_MAX   = '1;
   localparam logic [DEPTH_BITS-1:0]   DEPTH_MAX = DEPTH_BITS'(NUM_PAGES);

   localparam logic [CSR_IDX_BITS-1:0] REG_FIRST_PAGE = CSR_IDX_BITS'(0);

   localparam logic [MODE_BITS-1:0] MODE_ALLOC    = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_FREE     = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_INC_REF  = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_DEC_REF  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_READ_REF = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_DONATE   = 3'd5;

   typedef enum logic [2:0] {
      OP_ALLOC,
      OP_FREE,
      OP_INC_REF,
      OP_DEC_REF,
      OP_READ_REF,
      OP_DONATE,
      OP_BAD
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK,
      ST_EMPTY,
      ST_BAD,
      ST_UNDER,
      ST_OVER,
      ST_FULL
   } status_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_STACK,
      BK_EXEC
   } back_state_type;

   typedef struct packed {
      op_type               op;
      logic [PAGE_BITS-1:0] page;
   } item_type;

endpackage

### sv/refcounted_page_allocator.sv
// A request waits in the two-entry queue; the back end reads its count in IDLE (alloc on
// a non-empty list reads the stack top first and its count in STACK) and executes in EXEC
// once the response register is free, holding one request at a time for the read-then-write
// of the count memory. Reset: synchronous; the 32768-entry count table is then zeroed one
// entry per cycle with req_tready low; csr writes are taken throughout.
`timescale 1ns / 1ps

module refcounted_page_allocator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rap_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [rap_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [rap_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rap_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // page_index
   input  logic [rap_pkg::MODE_BITS-1:0]        req_tuser,  // mode
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rap_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,  // page_out, ref_count
   output logic [rap_pkg::STATUS_BITS-1:0]      rsp_tuser   // status
);

   logic              accept_en;
   logic              enq_valid;
   logic              enq_ready;
   rap_pkg::item_type enq_item;
   logic              deq_valid;
   logic              deq_ready;
   rap_pkg::item_type deq_item;

   rap_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .accept_en   (accept_en),
      .enq_valid   (enq_valid),
      .enq_ready   (enq_ready),
      .enq_item    (enq_item)
   );

   rap_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (enq_valid),
      .in_ready  (enq_ready),
      .in_item   (enq_item),
      .out_valid (deq_valid),
      .out_ready (deq_ready),
      .out_item  (deq_item)
   );

   rap_back u_back (
      .clock      (clock),
      .reset      (reset),
      .deq_valid  (deq_valid),
      .deq_ready  (deq_ready),
      .deq_item   (deq_item),
      .accept_en  (accept_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### sv/rap_front.sv
`timescale 1ns / 1ps

module rap_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rap_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [rap_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [rap_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rap_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // page_index
   input  logic [rap_pkg::MODE_BITS-1:0]        req_tuser,  // mode
   input  logic                                 accept_en,
   output logic                                 enq_valid,
   input  logic                                 enq_ready,
   output rap_pkg::item_type                    enq_item
);

   logic [rap_pkg::PAGE_BITS-1:0]    first_page_ff;
   logic [rap_pkg::PAGE_BITS-1:0]    first_page_in;
   logic [rap_pkg::CSR_IDX_BITS-1:0] csr_idx;
   logic                             csr_wr;
   logic [rap_pkg::PAGE_BITS-1:0]    page;
   rap_pkg::op_type                  op;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[rap_pkg::CSR_ADDR_BITS-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      first_page_in = first_page_ff;
      if (csr_wr && csr_idx == rap_pkg::REG_FIRST_PAGE) begin
         first_page_in = csr_pwdata[rap_pkg::PAGE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
      end else begin
         first_page_ff <= first_page_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_idx == rap_pkg::REG_FIRST_PAGE) begin
         csr_prdata = rap_pkg::CSR_DATA_BITS'(first_page_ff);
      end
   end

   assign page = req_tdata[rap_pkg::PAGE_BITS-1:0];

   // classify: undefined modes and unmanaged pages become OP_BAD
   always_comb begin
      unique case (req_tuser)
         rap_pkg::MODE_ALLOC:    op = rap_pkg::OP_ALLOC;
         rap_pkg::MODE_FREE:     op = rap_pkg::OP_FREE;
         rap_pkg::MODE_INC_REF:  op = rap_pkg::OP_INC_REF;
         rap_pkg::MODE_DEC_REF:  op = rap_pkg::OP_DEC_REF;
         rap_pkg::MODE_READ_REF: op = rap_pkg::OP_READ_REF;
         rap_pkg::MODE_DONATE:   op = rap_pkg::OP_DONATE;
         default:                op = rap_pkg::OP_BAD;
      endcase
      if (op != rap_pkg::OP_ALLOC && page < first_page_ff) begin
         op = rap_pkg::OP_BAD;
      end
   end

   assign enq_item.op   = op;
   assign enq_item.page = page;
   assign enq_valid     = req_tvalid & accept_en;
   assign req_tready    = enq_ready & accept_en;

endmodule

### sv/rap_queue.sv
`timescale 1ns / 1ps

module rap_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rap_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output rap_pkg::item_type out_item
);

   rap_pkg::item_type entries_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entries_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

### sv/rap_back.sv
`timescale 1ns / 1ps

module rap_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 deq_valid,
   output logic                                 deq_ready,
   input  rap_pkg::item_type                    deq_item,
   output logic                                 accept_en,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rap_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,  // page_out, ref_count
   output logic [rap_pkg::STATUS_BITS-1:0]      rsp_tuser   // status
);

   localparam int PB = rap_pkg::PAGE_BITS;
   localparam int RB = rap_pkg::REF_BITS;
   localparam int DB = rap_pkg::DEPTH_BITS;

   logic [RB-1:0] ref_mem [rap_pkg::NUM_PAGES];
   logic [PB-1:0] stk_mem [rap_pkg::NUM_PAGES];

   rap_pkg::back_state_type state_ff;
   rap_pkg::back_state_type state_in;
   logic [PB-1:0]           clr_addr_ff;
   logic [PB-1:0]           clr_addr_in;
   logic [DB-1:0]           depth_ff;
   logic [DB-1:0]           depth_in;
   rap_pkg::item_type       item_ff;
   rap_pkg::item_type       item_in;
   logic [RB-1:0]           ref_rdata_ff;
   logic [PB-1:0]           stk_rdata_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [PB-1:0]           rsp_page_ff;
   logic [RB-1:0]           rsp_count_ff;
   rap_pkg::status_type     rsp_status_ff;

   logic                    out_free;
   logic                    exec_fire;
   logic                    list_empty;
   logic                    list_full;
   logic                    deq_fire;
   logic                    ref_rd_en;
   logic [PB-1:0]           ref_raddr;
   logic                    stk_rd_en;
   logic [PB-1:0]           stk_raddr;
   logic                    ref_we;
   logic [PB-1:0]           ref_waddr;
   logic [RB-1:0]           ref_wdata;

   logic [PB-1:0]           res_page;
   logic [RB-1:0]           res_count;
   rap_pkg::status_type     res_status;
   logic                    res_we;
   logic [RB-1:0]           res_wdata;
   logic                    res_push;
   logic                    res_pop;
   logic [RB-1:0]           cnt_inc;
   logic [RB-1:0]           cnt_dec;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign list_empty = (depth_ff == '0);
   assign list_full  = (depth_ff == rap_pkg::DEPTH_MAX);
   assign deq_fire   = deq_valid & deq_ready;
   assign exec_fire  = (state_ff == rap_pkg::BK_EXEC) & out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rap_pkg::BK_CLEAR: begin
            if (&clr_addr_ff) state_in = rap_pkg::BK_IDLE;
         end
         rap_pkg::BK_IDLE: begin
            if (deq_valid) begin
               if (deq_item.op == rap_pkg::OP_ALLOC && !list_empty) begin
                  state_in = rap_pkg::BK_STACK;
               end else begin
                  state_in = rap_pkg::BK_EXEC;
               end
            end
         end
         rap_pkg::BK_STACK: state_in = rap_pkg::BK_EXEC;
         rap_pkg::BK_EXEC: begin
            if (out_free) state_in = rap_pkg::BK_IDLE;
         end
         default: state_in = rap_pkg::BK_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      deq_ready = 1'b0;
      accept_en = 1'b1;
      ref_rd_en = 1'b0;
      ref_raddr = deq_item.page;
      stk_rd_en = 1'b0;
      stk_raddr = PB'(depth_ff - DB'(1));
      unique case (state_ff)
         rap_pkg::BK_CLEAR: accept_en = 1'b0;
         rap_pkg::BK_IDLE: begin
            deq_ready = 1'b1;
            ref_rd_en = deq_valid;
            stk_rd_en = deq_valid & (deq_item.op == rap_pkg::OP_ALLOC) & ~list_empty;
         end
         rap_pkg::BK_STACK: begin
            ref_rd_en = 1'b1;
            ref_raddr = stk_rdata_ff;
         end
         rap_pkg::BK_EXEC: ;
         default: accept_en = 1'b0;
      endcase
   end

   // execute on the fetched count
   always_comb begin
      cnt_inc    = ref_rdata_ff + RB'(1);
      cnt_dec    = ref_rdata_ff - RB'(1);
      res_page   = item_ff.page;
      res_count  = '0;
      res_status = rap_pkg::ST_OK;
      res_we     = 1'b0;
      res_wdata  = ref_rdata_ff;
      res_push   = 1'b0;
      res_pop    = 1'b0;
      unique case (item_ff.op)
         rap_pkg::OP_ALLOC: begin
            if (list_empty) begin
               res_page   = '0;
               res_status = rap_pkg::ST_EMPTY;
            end else begin
               res_pop = 1'b1;
               if (ref_rdata_ff == rap_pkg::REF_MAX) begin
                  res_status = rap_pkg::ST_OVER;
                  res_count  = ref_rdata_ff;
               end else begin
                  res_we    = 1'b1;
                  res_wdata = cnt_inc;
                  res_count = cnt_inc;
               end
            end
         end
         rap_pkg::OP_FREE: begin
            if (ref_rdata_ff == '0) begin
               res_status = rap_pkg::ST_UNDER;
            end else begin
               res_we    = 1'b1;
               res_wdata = cnt_dec;
               res_count = cnt_dec;
               if (cnt_dec == '0) begin
                  if (list_full) res_status = rap_pkg::ST_FULL;
                  else res_push = 1'b1;
               end
            end
         end
         rap_pkg::OP_INC_REF: begin
            res_count = ref_rdata_ff;
            if (ref_rdata_ff == rap_pkg::REF_MAX) begin
               res_status = rap_pkg::ST_OVER;
            end else begin
               res_we    = 1'b1;
               res_wdata = cnt_inc;
               res_count = cnt_inc;
            end
         end
         rap_pkg::OP_DEC_REF: begin
            if (ref_rdata_ff == '0) begin
               res_status = rap_pkg::ST_UNDER;
            end else begin
               res_we    = 1'b1;
               res_wdata = cnt_dec;
               res_count = cnt_dec;
            end
         end
         rap_pkg::OP_READ_REF: res_count = ref_rdata_ff;
         rap_pkg::OP_DONATE: begin
            if (ref_rdata_ff != '0) begin
               res_status = rap_pkg::ST_BAD;
            end else if (list_full) begin
               res_status = rap_pkg::ST_FULL;
            end else begin
               res_push = 1'b1;
            end
         end
         rap_pkg::OP_BAD: res_status = rap_pkg::ST_BAD;
         default: res_status = rap_pkg::ST_BAD;
      endcase
   end

   always_comb begin
      ref_we    = exec_fire & res_we;
      ref_waddr = item_ff.page;
      ref_wdata = res_wdata;
      if (state_ff == rap_pkg::BK_CLEAR) begin
         ref_we    = 1'b1;
         ref_waddr = clr_addr_ff;
         ref_wdata = '0;
      end
   end

   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (state_ff == rap_pkg::BK_CLEAR) clr_addr_in = clr_addr_ff + PB'(1);
      depth_in = depth_ff;
      if (exec_fire && res_push) depth_in = depth_ff + DB'(1);
      else if (exec_fire && res_pop) depth_in = depth_ff - DB'(1);
      item_in = item_ff;
      if (deq_fire) item_in = deq_item;
      else if (state_ff == rap_pkg::BK_STACK) item_in.page = stk_rdata_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      if (exec_fire) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rap_pkg::BK_CLEAR;
         clr_addr_ff  <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (exec_fire) begin
         rsp_page_ff   <= res_page;
         rsp_count_ff  <= res_count;
         rsp_status_ff <= res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (ref_we) ref_mem[ref_waddr] <= ref_wdata;
      if (ref_rd_en) ref_rdata_ff <= ref_mem[ref_raddr];
   end

   always_ff @(posedge clock) begin
      if (exec_fire && res_push) stk_mem[depth_ff[PB-1:0]] <= item_ff.page;
      if (stk_rd_en) stk_rdata_ff <= stk_mem[stk_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rap_pkg::RSP_TDATA_BITS'({rsp_count_ff, rsp_page_ff});
   assign rsp_tuser  = rsp_status_ff;

endmodule
